// ===== design/m3inv_pkg.sv =====
// Package for the 3x3 fixed-point inverse: widths and shared types.
package m3inv_pkg;

	localparam int DataWidth = 32;
	localparam int FracBits  = 16;
	localparam int ProdW     = 2 * DataWidth + 1;   // cofactor width
	localparam int DetW      = 3 * DataWidth + 3;   // determinant width
	localparam int NumW      = ProdW + 2 * FracBits + 2;
	localparam int DenW      = DetW + 1;
	localparam int QW        = NumW;
	localparam int InW       = 9 * DataWidth;
	localparam int OutW      = 9 * DataWidth;

	typedef logic signed [DataWidth-1:0] elem_t;
	typedef logic signed [ProdW-1:0] cof_t;
	typedef logic signed [DetW-1:0] det_t;

	// one restoring-division slot in flight
	typedef struct packed {
		logic            neg;
		logic [DenW-1:0] rem;   // partial remainder, below the divisor whenever the divisor is nonzero
		logic [NumW-1:0] nq;    // numerator bits leave at the top, quotient bits enter below
	} div_slot_t;

endpackage

// ===== design/matrix3x3_inverse.sv =====
// Top level: pipelined 3x3 matrix inverse by adjugate, Q16.16.
// Throughput: one matrix per cycle while the output is not stalled; the long
// division is unrolled into one pipeline stage per quotient bit (NumW = 99),
// so the division chain sets the latency.
// A stall freezes the whole pipe. Reset clears all valid bits; data is not reset.
module matrix3x3_inverse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [m3inv_pkg::InW-1:0]     s_tdata,  // a00,a01,a02,a10,..,a22
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [m3inv_pkg::OutW-1:0]    m_tdata,  // inv00,..,inv22
	output logic [1:0]                    m_tuser   // singular, overflow
);
	import m3inv_pkg::*;

	localparam int NStg = NumW;

	logic adv;
	assign adv = ~m_tvalid | m_tready;
	assign s_tready = adv;

	// stage 1: 2x2 products
	elem_t a [9];
	always_comb begin
		for (int i = 0; i < 9; i++) a[i] = elem_t'(s_tdata[i*DataWidth +: DataWidth]);
	end

	logic signed [2*DataWidth-1:0] pp_s1 [18];
	elem_t a0_s1 [3];
	logic v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s1[(i*3+j)*2]   <= a[((i==0)?1:0)*3+((j==0)?1:0)] *
						a[((i==2)?1:2)*3+((j==2)?1:2)];
					pp_s1[(i*3+j)*2+1] <= a[((i==0)?1:0)*3+((j==2)?1:2)] *
						a[((i==2)?1:2)*3+((j==0)?1:0)];
				end
			end
			for (int j = 0; j < 3; j++) a0_s1[j] <= a[j];
		end
	end

	// stage 2: cofactors
	cof_t cof_s2 [9];
	elem_t a0_s2 [3];
	logic v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				if (((k / 3 + k % 3) % 2) == 1)
					cof_s2[k] <= ProdW'(pp_s1[2*k+1]) - ProdW'(pp_s1[2*k]);
				else
					cof_s2[k] <= ProdW'(pp_s1[2*k]) - ProdW'(pp_s1[2*k+1]);
			end
			a0_s2 <= a0_s1;
		end
	end

	// stage 3: row-0 terms (cofactor split in halves to keep multipliers near 32x33)
	localparam int LoW = DataWidth;
	localparam int HiW = ProdW - LoW;
	logic signed [DataWidth+LoW:0]   tl_s3 [3];
	logic signed [DataWidth+HiW-1:0] th_s3 [3];
	cof_t cof_s3 [9];
	logic v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				tl_s3[j] <= a0_s2[j] * $signed({1'b0, cof_s2[j][LoW-1:0]});
				th_s3[j] <= a0_s2[j] * $signed(cof_s2[j][ProdW-1:LoW]);
			end
			cof_s3 <= cof_s2;
		end
	end

	// stage 4: determinant
	det_t det_c;
	always_comb begin
		det_c = '0;
		for (int j = 0; j < 3; j++)
			det_c = det_c + DetW'(tl_s3[j]) + (DetW'(th_s3[j]) <<< LoW);
	end

	det_t det_s4;
	cof_t cof_s4 [9];
	logic v_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= det_c;
			cof_s4 <= cof_s3;
		end
	end

	// stage 5: operand set-up for the divider
	logic [DenW-1:0] den_s5;
	logic sing_s5;
	div_slot_t sl_s5 [9];
	logic v_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		logic [DetW-1:0] dabs;
		logic [ProdW-1:0] cabs;
		int ci;
		if (adv) begin
			dabs = det_s4[DetW-1] ? DetW'(-det_s4) : DetW'(det_s4);
			den_s5 <= {dabs, 1'b0};
			sing_s5 <= (det_s4 == '0);
			for (int k = 0; k < 9; k++) begin
				ci = (k % 3) * 3 + k / 3;   // transpose
				cabs = cof_s4[ci][ProdW-1] ? ProdW'(-cof_s4[ci]) : ProdW'(cof_s4[ci]);
				sl_s5[k].neg <= cof_s4[ci][ProdW-1] ^ det_s4[DetW-1];
				// numerator = 2*|C|*2^(2F) + |D|, consumed MSB first
				sl_s5[k].nq <= (NumW'(cabs) << (2 * FracBits + 1)) + NumW'(dabs);
				sl_s5[k].rem <= '0;
			end
		end
	end

	// divider: one quotient bit per stage
	div_slot_t dv [NStg+1][9];
	logic [DenW-1:0] dd [NStg+1];
	logic ds [NStg+1];
	logic dvv [NStg+1];
	assign dv[0] = sl_s5;
	assign dd[0] = den_s5;
	assign ds[0] = sing_s5;
	assign dvv[0] = v_s5;

	for (genvar g = 0; g < NStg; g++) begin : g_div
		div_slot_t nx [9];
		always_comb begin
			logic [DenW:0] r;
			for (int k = 0; k < 9; k++) begin
				nx[k].neg = dv[g][k].neg;
				// bring down the next numerator bit
				r = {dv[g][k].rem, dv[g][k].nq[NumW-1]};
				if (r >= {1'b0, dd[g]}) begin
					r = r - {1'b0, dd[g]};
					nx[k].nq = {dv[g][k].nq[NumW-2:0], 1'b1};
				end else begin
					nx[k].nq = {dv[g][k].nq[NumW-2:0], 1'b0};
				end
				nx[k].rem = r[DenW-1:0];
			end
		end
		div_slot_t st_q [9];
		logic [DenW-1:0] d_q;
		logic s_q, v_q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q <= 1'b0;
			else if (adv) v_q <= dvv[g];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				st_q <= nx;
				d_q <= dd[g];
				s_q <= ds[g];
			end
		end
		assign dv[g+1] = st_q;
		assign dd[g+1] = d_q;
		assign ds[g+1] = s_q;
		assign dvv[g+1] = v_q;
	end

	// saturation and output register
	logic [OutW-1:0] od_q;
	logic [1:0] ou_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (adv) m_tvalid <= dvv[NStg];
	end
	always_ff @(posedge clk) begin
		logic ov;
		logic [QW-1:0] mag, lim;
		if (adv) begin
			ov = 1'b0;
			for (int k = 0; k < 9; k++) begin
				mag = dv[NStg][k].nq;
				lim = QW'(1) << (DataWidth - 1);
				if (!dv[NStg][k].neg) lim = lim - QW'(1);
				if (mag > lim) begin
					mag = lim;
					ov = 1'b1;
				end
				if (dv[NStg][k].neg) mag = -mag;
				od_q[k*DataWidth +: DataWidth] <= ds[NStg] ? '0 : mag[DataWidth-1:0];
			end
			ou_q <= {ov & ~ds[NStg], ds[NStg]};
		end
	end
	assign m_tdata = od_q;
	assign m_tuser = ou_q;

	// a flagged singular word carries an all-zero matrix
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
		else $error("singular word with nonzero data");
	// a stalled output word is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output word changed under stall");
	// the pipe never stalls the input while the output is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input held off with empty output");

endmodule

// ===== dv/tb.sv =====
// Stream testbench for the 3x3 fixed-point inverse, with its own inverse predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import m3inv_pkg::*;

	localparam int NumRandom = 1100;
	localparam int IdleLimit = 5000;
	localparam int DrainAt   = 400;   // sender waits for every result here
	localparam logic signed [DataWidth-1:0] QOne = 1 <<< FracBits;
	localparam logic signed [DataWidth-1:0] QMax = {1'b0, {(DataWidth-1){1'b1}}};
	localparam logic signed [DataWidth-1:0] QMin = {1'b1, {(DataWidth-1){1'b0}}};

	typedef logic signed [255:0] big_t;
	typedef logic bool_t;
	typedef struct {
		logic [OutW-1:0] inv;
		logic            singular;
		logic            overflow;
	} inverse_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [InW-1:0]     s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OutW-1:0]    m_tdata;
	logic [1:0]         m_tuser;

	logic [InW-1:0] matrix_q[$];
	inverse_t       inverse_q[$];
	int             n_errors = 0;
	int             n_sent = 0;
	int             send_gap = 0;
	int             ready_gap = 0;
	int             idle_cycles = 0;
	bool_t          burst;

	matrix3x3_inverse DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// exact adjugate over determinant, rounded half away from zero, saturated
	function automatic inverse_t predict_inverse(input logic [InW-1:0] mat);
		inverse_t   r;
		elem_t      e;
		big_t       a[3][3];
		big_t       cof[3][3];
		big_t       det, c;
		logic [255:0] num, den, q, lim;
		logic       neg;
		int         r0, r1, c0, c1;
		r = '{default: '0};
		for (int i = 0; i < 9; i++) begin
			e = mat[i*DataWidth +: DataWidth];
			a[i/3][i%3] = e;
		end
		for (int i = 0; i < 3; i++) begin
			r0 = (i == 0) ? 1 : 0;
			r1 = (i == 2) ? 1 : 2;
			for (int j = 0; j < 3; j++) begin
				c0 = (j == 0) ? 1 : 0;
				c1 = (j == 2) ? 1 : 2;
				c = a[r0][c0] * a[r1][c1] - a[r0][c1] * a[r1][c0];
				cof[i][j] = ((i + j) % 2) ? -c : c;
			end
		end
		det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				c = cof[j][i];
				neg = c[255] ^ det[255];
				num = c[255] ? -c : c;
				den = det[255] ? -det : det;
				num = (num << (2 * FracBits + 1)) + den;
				q = num / (den << 1);
				lim = neg ? (256'd1 << (DataWidth - 1)) : (256'd1 << (DataWidth - 1)) - 1;
				if (q > lim) begin
					q = lim;
					r.overflow = 1'b1;
				end
				if (neg)
					q = -q;
				r.inv[(i*3+j)*DataWidth +: DataWidth] = q[DataWidth-1:0];
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (burst || p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic report_mismatch(input string what, input logic [DataWidth-1:0] want,
			input logic [DataWidth-1:0] got);
		n_errors++;
		$display("mismatch %s: expected %h got %h (word %0d pending)", what, want, got,
			inverse_q.size());
	endtask

	function automatic logic [InW-1:0] pack(input elem_t m[9]);
		logic [InW-1:0] d;
		for (int k = 0; k < 9; k++)
			d[k*DataWidth +: DataWidth] = m[k];
		return d;
	endfunction

	function automatic elem_t small_q(input int span);
		return elem_t'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic logic [InW-1:0] random_matrix();
		elem_t m[9];
		int    kind, rw;
		kind = $urandom_range(0, 99);
		for (int k = 0; k < 9; k++) begin
			if (kind < 40)
				m[k] = small_q(4 * QOne);
			else if (kind < 60)
				m[k] = $urandom;
			else if (kind < 70)
				m[k] = small_q(8) <<< FracBits;
			else
				m[k] = small_q(QOne);
		end
		if (kind >= 70 && kind < 85) begin
			// singular: copy one row onto another, or zero a row
			rw = $urandom_range(0, 2);
			for (int c = 0; c < 3; c++)
				m[((rw + 1) % 3) * 3 + c] = (kind < 78) ? m[rw * 3 + c] : '0;
		end else if (kind >= 85) begin
			// near-zero diagonal can drive the inverse past full scale
			m = '{default: '0};
			for (int c = 0; c < 3; c++)
				m[c * 4] = small_q(64);
		end
		return pack(m);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				inverse_q.push_back(predict_inverse(s_tdata));
				n_sent++;
			end
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (matrix_q.size() != 0 &&
					!(n_sent == DrainAt && inverse_q.size() != 0)) begin
				s_tdata <= matrix_q.pop_front();
				s_tvalid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		inverse_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (inverse_q.size() == 0) begin
					n_errors++;
					$display("unexpected output word %h", m_tdata);
				end else begin
					want = inverse_q.pop_front();
					for (int k = 0; k < 9; k++)
						if (m_tdata[k*DataWidth +: DataWidth] !== want.inv[k*DataWidth +: DataWidth])
							report_mismatch($sformatf("inv%0d%0d", k / 3, k % 3),
								want.inv[k*DataWidth +: DataWidth],
								m_tdata[k*DataWidth +: DataWidth]);
					if (m_tuser[0] !== want.singular)
						report_mismatch("singular", DataWidth'(want.singular),
							DataWidth'(m_tuser[0]));
					if (m_tuser[1] !== want.overflow)
						report_mismatch("overflow", DataWidth'(want.overflow),
							DataWidth'(m_tuser[1]));
				end
			end
			if (ready_gap > 0) begin
				ready_gap <= ready_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				ready_gap <= pick_gap();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("** matrix3x3_inverse: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		elem_t m[9];
		burst = 1'b0;
		// directed: identity, zero, extremes, scaled and permuted cases
		m = '{QOne, 0, 0, 0, QOne, 0, 0, 0, QOne};
		matrix_q.push_back(pack(m));
		matrix_q.push_back('0);
		matrix_q.push_back({9{QMax}});
		matrix_q.push_back({9{QMin}});
		matrix_q.push_back('1);
		m = '{QMax, 0, 0, 0, QMax, 0, 0, 0, QMax};
		matrix_q.push_back(pack(m));
		m = '{QMin, 0, 0, 0, QMin, 0, 0, 0, QMin};
		matrix_q.push_back(pack(m));
		m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		matrix_q.push_back(pack(m));
		m = '{-QOne, 0, 0, 0, -QOne, 0, 0, 0, -QOne};
		matrix_q.push_back(pack(m));
		m = '{0, QOne, 0, 0, 0, QOne, QOne, 0, 0};
		matrix_q.push_back(pack(m));
		m = '{2 * QOne, QOne, 0, QOne, 2 * QOne, QOne, 0, QOne, 2 * QOne};
		matrix_q.push_back(pack(m));
		m = '{3 * QOne, 0, 0, 0, 3 * QOne, 0, 0, 0, 3 * QOne};
		matrix_q.push_back(pack(m));
		m = '{QMax, QMin, QMax, QMin, QMax, QMin, QMax, QMin, QMin};
		matrix_q.push_back(pack(m));
		m = '{QOne, 2 * QOne, 3 * QOne, 4 * QOne, 5 * QOne, 6 * QOne, 7 * QOne, 8 * QOne,
			9 * QOne};
		matrix_q.push_back(pack(m));
		m = '{QMax, 0, 0, 0, 1, 0, 0, 0, QMin};
		matrix_q.push_back(pack(m));
		for (int k = 0; k < NumRandom; k++) begin
			if (k % 150 == 0)
				matrix_q.push_back(random_matrix());
			matrix_q.push_back(random_matrix());
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// alternate bursts without gaps and normal idling
		while (matrix_q.size() != 0 || s_tvalid) begin
			@(posedge clk);
			if ($urandom_range(0, 499) == 0)
				burst = ~burst;
		end
		burst = 1'b0;
		while (inverse_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (n_errors == 0)
			$display("** matrix3x3_inverse: PASSED **");
		else
			$display("** matrix3x3_inverse: FAILED **");
		$finish;
	end
endmodule
